FILE: design/sorted_page_cache_directory_assert.svh
// Assertion macros used by the directory top level.
`ifndef SORTED_PAGE_CACHE_DIRECTORY_ASSERT_SVH
`define SORTED_PAGE_CACHE_DIRECTORY_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define SPCD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Implication whose consequent is checked in the next cycle.
`define SPCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: design/spcd_pkg.sv
// Shared types and constants of the page cache directory.
package spcd_pkg;
	localparam int DIRTY_ENTRIES_DEF = 32;
	localparam int CLEAN_ENTRIES_DEF = 64;
	localparam logic [2:0] ACT_LOOKUP  = 3'd0;
	localparam logic [2:0] ACT_FILL    = 3'd1;
	localparam logic [2:0] ACT_WRITE   = 3'd2;
	localparam logic [2:0] ACT_PURGE   = 3'd3;
	localparam logic [2:0] ACT_DRAIN   = 3'd4;
	localparam logic [2:0] ACT_DISCARD = 3'd5;
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_MISS  = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_CACHED = 2'd3;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] page_id;
		logic [15:0] handle;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        in_dirty;
		logic [31:0] page_out;
		logic [15:0] handle_out;
		logic        last;
	} rsp_t;

	// Command to a row of cells, applied to all cells together.
	typedef struct packed {
		logic        ins;    // insert key at position where it belongs
		logic        rem;    // remove entry equal to key
		logic        upd;    // overwrite handle of entry equal to key
		logic        shl;    // shift all toward the head (drain)
		logic        clr;    // empty the row
		logic [31:0] key;
		logic [15:0] hdl;
	} cmd_t;

	// Summary of a row seen through its compare flags.
	typedef struct packed {
		logic        hit;
		logic [15:0] hit_hdl;
		logic        full;
		logic        empty;
		logic [31:0] head_key;
		logic [15:0] head_hdl;
		logic        head_last;
	} sts_t;
endpackage

FILE: design/spcd_if.sv
// Valid/ready channel carrying one payload beat.
interface spcd_if #(parameter type T = logic) (input logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/sorted_page_cache_directory.sv
// Top level of the sorted page cache directory.
// Requests enter on req (action, page_id, handle); results leave on rsp
// (status, in_dirty, page_out, handle_out, last). Both are valid/ready
// channels. Each table is a row of cells kept in ascending page order; a
// request is compared against every cell at once, and inserts or removals
// move the entries by one cell at once.
// A request passes through capture, compare and update, and the result beat.
// Drain emits one dirty entry a cycle from the head of the row while the
// receiver is ready and the row shifts towards its head; last is set on
// the final beat, then both rows are emptied.
// A new request is taken once the previous result beat has been taken.
// When the receiver stalls the result register holds and no request is
// taken. Reset empties both rows at once; no clearing pass is needed.
module sorted_page_cache_directory #(
	parameter int DIRTY_ENTRIES = spcd_pkg::DIRTY_ENTRIES_DEF,
	parameter int CLEAN_ENTRIES = spcd_pkg::CLEAN_ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	spcd_if.sink   req,
	spcd_if.source rsp
);
	import spcd_pkg::*;
	`include "sorted_page_cache_directory_assert.svh"

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_EXEC  = 4'b0010,
		S_DRAIN = 4'b0100,
		S_OUT   = 4'b1000
	} state_t;

	state_t state_q;
	req_t   r_q;
	rsp_t   o_q;
	rsp_t   o_d;
	cmd_t   dcmd, ccmd;
	sts_t   dsts, csts;

	spcd_row #(.N(DIRTY_ENTRIES)) u_dirty (.clk, .arst_n, .cmd(dcmd), .sts(dsts));
	spcd_row #(.N(CLEAN_ENTRIES)) u_clean (.clk, .arst_n, .cmd(ccmd), .sts(csts));

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = (state_q == S_OUT) || (state_q == S_DRAIN && !dsts.empty);
	assign rsp.data  = (state_q == S_DRAIN) ?
		rsp_t'{status: ST_OK, in_dirty: 1'b1, page_out: dsts.head_key,
		  handle_out: dsts.head_hdl, last: dsts.head_last} : o_q;

	always_comb begin
		dcmd = '0;
		ccmd = '0;
		dcmd.key = r_q.page_id; dcmd.hdl = r_q.handle;
		ccmd.key = r_q.page_id; ccmd.hdl = r_q.handle;
		if (state_q == S_EXEC) begin
			unique case (r_q.action)
				ACT_FILL:  ccmd.ins = !dsts.hit && !csts.hit && !csts.full;
				ACT_WRITE: begin
					dcmd.upd = dsts.hit;
					dcmd.ins = !dsts.hit && !dsts.full;
					ccmd.rem = !dsts.hit && !dsts.full && csts.hit;
				end
				ACT_PURGE: begin
					dcmd.upd = dsts.hit; dcmd.hdl = '0;
					ccmd.upd = csts.hit; ccmd.hdl = '0;
				end
				// empty drain still clears both rows
				ACT_DRAIN: begin
					if (dsts.empty) begin
						dcmd.clr = 1'b1; ccmd.clr = 1'b1;
					end
				end
				ACT_DISCARD: begin
					dcmd.clr = 1'b1; ccmd.clr = 1'b1;
				end
				default: ;
			endcase
		end else if (state_q == S_DRAIN && rsp.ready) begin
			dcmd.shl = 1'b1;
			if (dsts.head_last) begin
				dcmd.clr = 1'b1; ccmd.clr = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:  if (req.valid) state_q <= S_EXEC;
				S_EXEC:  state_q <= (r_q.action == ACT_DRAIN && !dsts.empty) ?
					S_DRAIN : S_OUT;
				S_DRAIN: if (rsp.ready && dsts.head_last) state_q <= S_IDLE;
				S_OUT:   if (rsp.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		o_d = '{status: ST_MISS, in_dirty: 1'b0, page_out: 32'd0,
			handle_out: 16'd0, last: 1'b1};
		unique case (r_q.action)
			ACT_LOOKUP: begin
				o_d.page_out = r_q.page_id;
				if (dsts.hit) begin
					o_d.status = ST_OK; o_d.in_dirty = 1'b1;
					o_d.handle_out = dsts.hit_hdl;
				end else if (csts.hit) begin
					o_d.status = ST_OK; o_d.handle_out = csts.hit_hdl;
				end
			end
			ACT_FILL: begin
				o_d.page_out = r_q.page_id;
				if (dsts.hit) begin
					o_d.status = ST_CACHED; o_d.in_dirty = 1'b1;
					o_d.handle_out = dsts.hit_hdl;
				end else if (csts.hit) begin
					o_d.status = ST_CACHED; o_d.handle_out = csts.hit_hdl;
				end else begin
					o_d.status = csts.full ? ST_FULL : ST_OK;
					o_d.handle_out = r_q.handle;
				end
			end
			ACT_WRITE: begin
				o_d.page_out = r_q.page_id;
				o_d.handle_out = r_q.handle;
				if (!dsts.hit && dsts.full) begin
					o_d.status = ST_FULL;
				end else begin
					o_d.status = ST_OK; o_d.in_dirty = 1'b1;
				end
			end
			ACT_PURGE: begin
				o_d.page_out = r_q.page_id;
				o_d.status = (dsts.hit || csts.hit) ? ST_OK : ST_MISS;
				o_d.in_dirty = dsts.hit;
			end
			ACT_DRAIN: ;
			ACT_DISCARD: o_d.status = ST_OK;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid)
			r_q <= req.data;
		if (state_q == S_EXEC)
			o_q <= o_d;
	end

	`SPCD_ASSERT_IMP(a_ready_idle, clk, arst_n, req.ready, !rsp.valid)
	`SPCD_ASSERT_IMP(a_drain_dirty, clk, arst_n,
		state_q == S_DRAIN && rsp.valid, rsp.data.in_dirty)
	`SPCD_ASSERT_NEXT(a_out_hold, clk, arst_n,
		state_q == S_OUT && !rsp.ready, state_q == S_OUT && $stable(o_q))
endmodule

FILE: design/spcd_cell.sv
// One entry of a sorted row: holds key and handle, trades with neighbours.
module spcd_cell (
	input  logic        clk,
	input  logic        arst_n,
	input  spcd_pkg::cmd_t cmd,
	input  logic        prev_v,
	input  logic [31:0] prev_key,
	input  logic [15:0] prev_hdl,
	input  logic        prev_lt,
	input  logic        next_v,
	input  logic [31:0] next_key,
	input  logic [15:0] next_hdl,
	input  logic        prev_eq_seen,
	output logic        v,
	output logic [31:0] key,
	output logic [15:0] hdl,
	output logic        lt,
	output logic        eq
);
	import spcd_pkg::*;
	logic        v_q;
	logic [31:0] key_q;
	logic [15:0] hdl_q;

	assign v   = v_q;
	assign key = key_q;
	assign hdl = hdl_q;
	assign lt  = v_q && (key_q < cmd.key);
	assign eq  = v_q && (key_q == cmd.key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (cmd.clr) begin
			v_q <= 1'b0;
		end else if (cmd.ins) begin
			// keys below stay; the slot at the boundary takes the new key
			if (!lt) begin
				if (prev_lt) begin
					v_q <= 1'b1;
					key_q <= cmd.key;
					hdl_q <= cmd.hdl;
				end else if (prev_v) begin
					v_q <= prev_v;
					key_q <= prev_key;
					hdl_q <= prev_hdl;
				end
			end
		end else if (cmd.rem) begin
			if (eq || prev_eq_seen) begin
				v_q <= next_v;
				key_q <= next_key;
				hdl_q <= next_hdl;
			end
		end else if (cmd.upd) begin
			if (eq)
				hdl_q <= cmd.hdl;
		end else if (cmd.shl) begin
			v_q <= next_v;
			key_q <= next_key;
			hdl_q <= next_hdl;
		end
	end
endmodule

FILE: design/spcd_row.sv
// Sorted row of cells with a combinational status summary.
module spcd_row #(
	parameter int N = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  spcd_pkg::cmd_t cmd,
	output spcd_pkg::sts_t sts
);
	import spcd_pkg::*;
	logic [N-1:0]  v, lt, eq, eqs;
	logic [31:0]   key [N];
	logic [15:0]   hdl [N];
	logic [15:0]   hh;

	// Ripple "equal seen" along the row; used only on removal.
	always_comb begin
		eqs[0] = 1'b0;
		for (int i = 1; i < N; i++)
			eqs[i] = eqs[i-1] | eq[i-1];
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic        pv, plt, nv;
		logic [31:0] pk, nk;
		logic [15:0] ph, nh;
		if (i == 0) begin : g_head
			assign pv = 1'b1; assign plt = 1'b1;
			assign pk = '0;   assign ph = '0;
		end else begin : g_mid
			assign pv = v[i-1]; assign plt = lt[i-1];
			assign pk = key[i-1]; assign ph = hdl[i-1];
		end
		if (i == N-1) begin : g_tail
			assign nv = 1'b0; assign nk = '0; assign nh = '0;
		end else begin : g_body
			assign nv = v[i+1]; assign nk = key[i+1]; assign nh = hdl[i+1];
		end
		spcd_cell u_cell (
			.clk, .arst_n, .cmd,
			.prev_v(pv), .prev_key(pk), .prev_hdl(ph), .prev_lt(plt),
			.next_v(nv), .next_key(nk), .next_hdl(nh), .prev_eq_seen(eqs[i]),
			.v(v[i]), .key(key[i]), .hdl(hdl[i]), .lt(lt[i]), .eq(eq[i])
		);
	end

	always_comb begin
		hh = '0;
		for (int i = 0; i < N; i++)
			hh |= eq[i] ? hdl[i] : 16'd0;
	end

	assign sts.hit       = |eq;
	assign sts.hit_hdl   = hh;
	assign sts.full      = v[N-1];
	assign sts.empty     = !v[0];
	assign sts.head_key  = key[0];
	assign sts.head_hdl  = hdl[0];
	assign sts.head_last = !v[1];
endmodule
